[hw/rtl/gtf_pkg.sv]
// Shared types, constants and helpers for the grid tile fit and clip unit.
`default_nettype none
package gtf_pkg;
  localparam int MAX_GRID = 16;
  localparam int DVD_W = 56;
  localparam int DVS_W = 40;

  localparam logic [2:0] CFG_COLS   = 3'd0;
  localparam logic [2:0] CFG_ROWS   = 3'd1;
  localparam logic [2:0] CFG_LINE   = 3'd2;
  localparam logic [2:0] CFG_VIEW_W = 3'd3;
  localparam logic [2:0] CFG_VIEW_H = 3'd4;
  localparam logic [2:0] CFG_ZOOM   = 3'd5;
  localparam logic [2:0] CFG_PAN_X  = 3'd6;
  localparam logic [2:0] CFG_PAN_Y  = 3'd7;

  typedef struct packed {
    logic [4:0]         cols;
    logic [4:0]         rows;
    logic [15:0]        line;
    logic [13:0]        view_w;
    logic [13:0]        view_h;
    logic [15:0]        zoom;
    logic signed [23:0] pan_x;
    logic signed [23:0] pan_y;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [13:0] tw;
    logic [13:0] th;
    logic        clr;
  } ent_t;

  typedef struct packed {
    logic signed [23:0] dx0;
    logic signed [23:0] dy0;
    logic signed [23:0] dx1;
    logic signed [23:0] dy1;
    logic signed [23:0] sx0;
    logic signed [23:0] sy0;
    logic signed [23:0] sx1;
    logic signed [23:0] sy1;
    logic               clr;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) r = 24'sh7FFFFF;
    else if (v < -64'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic [4:0] grid_count(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'(MAX_GRID)) r = 5'(MAX_GRID);
    else r = v;
    return r;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/gtf_front.sv]
// Front part: accept transactions, classify them and queue them for the back part.
`default_nettype none
module gtf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [3:0]    in_cell_row,
  input  wire logic [3:0]    in_cell_col,
  input  wire logic [13:0]   in_source_w,
  input  wire logic [13:0]   in_source_h,
  output logic               head_valid,
  output gtf_pkg::ent_t      head,
  input  wire logic          pop
);
  gtf_pkg::ent_t ent_r [2];
  gtf_pkg::ent_t ent_nxt;
  logic          wr_r, rd_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rd_r];

  always_comb begin
    ent_nxt.row = in_cell_row;
    ent_nxt.col = in_cell_col;
    ent_nxt.tw  = (in_source_w == 14'd0) ? 14'd1 : in_source_w;
    ent_nxt.th  = (in_source_h == 14'd0) ? 14'd1 : in_source_h;
    ent_nxt.clr = (in_cell_row == 4'd0) && (in_cell_col == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= ent_nxt;
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

[hw/rtl/gtf_div.sv]
// Shared unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module gtf_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gtf_pkg::div_req_t         req,
  output logic                           done,
  output logic [gtf_pkg::DVD_W-1:0]      quot
);
  logic [gtf_pkg::DVD_W-1:0] dvd_r;
  logic [gtf_pkg::DVS_W-1:0] dvs_r;
  logic [gtf_pkg::DVS_W:0]   rem_r, rem_sh;
  logic [5:0]                cnt_r;
  logic                      busy_r, done_r, ge;

  assign rem_sh = {rem_r[gtf_pkg::DVS_W-1:0], dvd_r[gtf_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign done   = done_r;
  assign quot   = dvd_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      cnt_r <= 6'(gtf_pkg::DVD_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      dvd_r <= {dvd_r[gtf_pkg::DVD_W-2:0], ge};
      cnt_r <= cnt_r - 6'd1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd0) && !req.start;
      if (req.start) busy_r <= 1'b1;
      else if (cnt_r == 6'd0) busy_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/gtf_back.sv]
// Back part: sequence the fit, zoom, pan and clip steps for one queued transaction.
`default_nettype none
module gtf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gtf_pkg::cfg_t cfg,
  input  wire logic          head_valid,
  input  wire gtf_pkg::ent_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output gtf_pkg::res_t      res
);
  localparam logic [4:0] ST_IDLE = 5'd0,  ST_CW   = 5'd1,  ST_CH   = 5'd2,  ST_CMP  = 5'd3;
  localparam logic [4:0] ST_SEL  = 5'd4,  ST_FITM = 5'd5,  ST_FIT  = 5'd6,  ST_EXTM = 5'd7;
  localparam logic [4:0] ST_EXT  = 5'd8,  ST_POS  = 5'd9,  ST_CL0  = 5'd10, ST_CL0D = 5'd11;
  localparam logic [4:0] ST_CL0W = 5'd12, ST_CL1  = 5'd13, ST_CL1D = 5'd14, ST_CL1W = 5'd15;
  localparam logic [4:0] ST_FIN  = 5'd16, ST_OUT  = 5'd17, ST_WAIT = 5'd18;

  logic [4:0]  state_r, ret_r;
  logic        ax_r, ov_r;
  logic [22:0] cw_r, ch_r, num_r, fit_r;
  logic [13:0] den_r;
  logic [36:0] pa_r, pb_r, p_r;
  logic [52:0] p2_r;
  logic [38:0] nz_r;
  logic [46:0] m_r;
  logic signed [39:0] a_r, b_r, left_r;
  logic signed [57:0] c0_r, c1_r;
  logic signed [23:0] rx0_r, rx1_r, sx0_r, sx1_r, ry0_r, ry1_r, sy0_r, sy1_r;
  gtf_pkg::res_t res_r;

  gtf_pkg::div_req_t         dreq;
  logic                      ddone;
  logic [gtf_pkg::DVD_W-1:0] dq;

  logic [4:0]  cols, rows;
  logic signed [23:0] nx, ny;
  logic [22:0] cell_len;
  logic [13:0] size;
  logic [3:0]  idx;
  logic signed [23:0] pan;
  logic [23:0] pitch;
  logic [27:0] left_u;
  logic signed [39:0] cell_s, fit_s, line_s, ext_s, a_new, lc, bound;
  logic [32:0] oob0, oob1;
  logic        nz_ok;

  gtf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  assign cols = gtf_pkg::grid_count(cfg.cols);
  assign rows = gtf_pkg::grid_count(cfg.rows);
  assign nx = $signed({2'b0, cfg.view_w, 8'b0}) - $signed(24'(20'(cols - 5'd1) * 20'(cfg.line)));
  assign ny = $signed({2'b0, cfg.view_h, 8'b0}) - $signed(24'(20'(rows - 5'd1) * 20'(cfg.line)));

  assign cell_len = ax_r ? ch_r : cw_r;
  assign size     = ax_r ? head.th : head.tw;
  assign idx      = ax_r ? head.row : head.col;
  assign pan      = ax_r ? cfg.pan_y : cfg.pan_x;
  assign pitch    = 24'(cell_len) + 24'(cfg.line);
  assign left_u   = 28'(pitch) * 28'(idx);
  assign cell_s   = $signed({17'b0, cell_len});
  assign fit_s  = $signed({17'b0, fit_r});
  assign line_s = $signed({24'b0, cfg.line});
  assign ext_s  = $signed({1'b0, dq[38:0]});
  assign a_new  = ((cell_s - fit_s) >>> 1) + 40'(pan) + $signed({12'b0, left_u});
  assign lc     = left_r + cell_s;
  assign bound  = lc + line_s;
  assign oob0   = 33'(left_r - a_r);
  assign oob1   = 33'(b_r - bound);
  assign nz_ok  = (num_r != 23'd0) && (cfg.zoom != 16'd0);

  assign pop       = (state_r == ST_OUT) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign res       = res_r;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    unique case (state_r) inside
      ST_CW: begin
        dreq.start    = 1'b1;
        dreq.dividend = nx[23] ? '0 : 56'(nx);
        dreq.divisor  = 40'(cols);
      end
      ST_CH: begin
        dreq.start    = 1'b1;
        dreq.dividend = ny[23] ? '0 : 56'(ny);
        dreq.divisor  = 40'(rows);
      end
      ST_FIT: begin
        dreq.start    = 1'b1;
        dreq.dividend = 56'(p_r);
        dreq.divisor  = 40'(den_r);
      end
      ST_EXT: begin
        dreq.start    = 1'b1;
        dreq.dividend = 56'(p2_r);
        dreq.divisor  = 40'({den_r, 8'b0});
      end
      ST_CL0D, ST_CL1D: begin
        dreq.start    = 1'b1;
        dreq.dividend = 56'({m_r, 8'b0});
        dreq.divisor  = 40'(nz_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      ax_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_ready && !pop) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (head_valid) begin
          ax_r    <= 1'b0;
          state_r <= ST_CW;
        end
        ST_CW: begin
          ret_r <= ST_CH;
          state_r <= ST_WAIT;
        end
        ST_CH: begin
          cw_r    <= dq[22:0];
          ret_r   <= ST_CMP;
          state_r <= ST_WAIT;
        end
        ST_CMP: begin
          ch_r    <= dq[22:0];
          pa_r    <= 37'(cw_r) * 37'(head.th);
          pb_r    <= 37'(dq[22:0]) * 37'(head.tw);
          state_r <= ST_SEL;
        end
        ST_SEL: begin
          num_r   <= (pa_r <= pb_r) ? cw_r : ch_r;
          den_r   <= (pa_r <= pb_r) ? head.tw : head.th;
          state_r <= ST_FITM;
        end
        ST_FITM: begin
          nz_r    <= 39'(num_r) * 39'(cfg.zoom);
          p_r     <= 37'(num_r) * 37'(size);
          state_r <= ST_FIT;
        end
        ST_FIT: begin
          ret_r   <= ST_EXTM;
          state_r <= ST_WAIT;
        end
        ST_EXTM: begin
          fit_r   <= dq[22:0];
          p2_r    <= 53'(p_r) * 53'(cfg.zoom);
          state_r <= ST_EXT;
        end
        ST_EXT: begin
          ret_r   <= ST_POS;
          state_r <= ST_WAIT;
        end
        ST_POS: begin
          a_r     <= a_new;
          b_r     <= a_new + ext_s;
          left_r  <= $signed({12'b0, left_u});
          c0_r    <= '0;
          c1_r    <= $signed({36'b0, size, 8'b0});
          state_r <= ST_CL0;
        end
        ST_CL0: begin
          if (a_r < left_r) begin
            m_r     <= 47'(oob0) * 47'(den_r);
            a_r     <= left_r;
            state_r <= nz_ok ? ST_CL0D : ST_CL1;
          end else if (a_r >= lc) begin
            a_r     <= lc;
            b_r     <= bound;
            state_r <= ST_CL1;
          end else begin
            state_r <= ST_CL1;
          end
        end
        ST_CL0D: begin
          ret_r   <= ST_CL0W;
          state_r <= ST_WAIT;
        end
        ST_CL0W: begin
          c0_r    <= $signed({2'b0, dq});
          state_r <= ST_CL1;
        end
        ST_CL1: begin
          if (b_r > bound) begin
            m_r     <= 47'(oob1) * 47'(den_r);
            b_r     <= bound;
            state_r <= nz_ok ? ST_CL1D : ST_FIN;
          end else if (b_r < left_r) begin
            b_r     <= left_r;
            a_r     <= left_r - line_s;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_CL1D: begin
          ret_r   <= ST_CL1W;
          state_r <= ST_WAIT;
        end
        ST_CL1W: begin
          c1_r    <= c1_r - $signed({2'b0, dq});
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!ax_r) begin
            rx0_r   <= gtf_pkg::sat24(64'(a_r));
            rx1_r   <= gtf_pkg::sat24(64'(b_r));
            sx0_r   <= gtf_pkg::sat24(64'(c0_r));
            sx1_r   <= gtf_pkg::sat24(64'(c1_r));
            ax_r    <= 1'b1;
            state_r <= ST_FITM;
          end else begin
            ry0_r   <= gtf_pkg::sat24(64'(a_r));
            ry1_r   <= gtf_pkg::sat24(64'(b_r));
            sy0_r   <= gtf_pkg::sat24(64'(c0_r));
            sy1_r   <= gtf_pkg::sat24(64'(c1_r));
            state_r <= ST_OUT;
          end
        end
        ST_OUT: if (pop) begin
          ov_r    <= 1'b1;
          state_r <= ST_IDLE;
        end
        ST_WAIT: if (ddone) state_r <= ret_r;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r.dx0 <= rx0_r;
      res_r.dx1 <= rx1_r;
      res_r.sx0 <= sx0_r;
      res_r.sx1 <= sx1_r;
      res_r.dy0 <= ry0_r;
      res_r.dy1 <= ry1_r;
      res_r.sy0 <= sy0_r;
      res_r.sy1 <= sy1_r;
      res_r.clr <= head.clr;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> (state_r == ST_WAIT)) else $error("divider finished outside wait state");
  a_pop_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_OUT) && head_valid) else $error("queue popped out of sequence");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(res_r))) else $error("result dropped while stalled");
endmodule
`default_nettype wire

[hw/rtl/grid_tile_fit_and_clip_unit.sv]
// Top level of the grid tile fit and clip unit: config registers, front and back parts.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | cell_row, cell_col, source_w, source_h
//  out_    | output    | out_valid / out_ready  | dest_*, src_*, clear_border
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each transaction holds the back part through the divisions of the one shared 56-step
// divider (six divisions always, up to four more for clipped edges).
// A two-entry queue takes new transactions while the back part works or a result waits.
// Synchronous active-low reset restores the config defaults and empties the queue.
// cfg_ready is always high.
`default_nettype none
module grid_tile_fit_and_clip_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_cell_row,
  input  wire logic [3:0]         in_cell_col,
  input  wire logic [13:0]        in_source_w,
  input  wire logic [13:0]        in_source_h,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_dest_x0,
  output logic signed [23:0]      out_dest_y0,
  output logic signed [23:0]      out_dest_x1,
  output logic signed [23:0]      out_dest_y1,
  output logic signed [23:0]      out_src_x0,
  output logic signed [23:0]      out_src_y0,
  output logic signed [23:0]      out_src_x1,
  output logic signed [23:0]      out_src_y1,
  output logic                    out_clear_border,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  gtf_pkg::cfg_t cfg_r;
  gtf_pkg::ent_t head;
  gtf_pkg::res_t res;
  logic          head_valid, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols   <= 5'd1;
      cfg_r.rows   <= 5'd1;
      cfg_r.line   <= 16'd256;
      cfg_r.view_w <= 14'd1920;
      cfg_r.view_h <= 14'd1080;
      cfg_r.zoom   <= 16'd256;
      cfg_r.pan_x  <= '0;
      cfg_r.pan_y  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gtf_pkg::CFG_COLS:   cfg_r.cols   <= cfg_data[4:0];
        gtf_pkg::CFG_ROWS:   cfg_r.rows   <= cfg_data[4:0];
        gtf_pkg::CFG_LINE:   cfg_r.line   <= cfg_data[15:0];
        gtf_pkg::CFG_VIEW_W: cfg_r.view_w <= cfg_data[13:0];
        gtf_pkg::CFG_VIEW_H: cfg_r.view_h <= cfg_data[13:0];
        gtf_pkg::CFG_ZOOM:   cfg_r.zoom   <= cfg_data[15:0];
        gtf_pkg::CFG_PAN_X:  cfg_r.pan_x  <= cfg_data;
        gtf_pkg::CFG_PAN_Y:  cfg_r.pan_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  gtf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .in_source_w(in_source_w), .in_source_h(in_source_h),
    .head_valid(head_valid), .head(head), .pop(pop)
  );

  gtf_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head_valid(head_valid), .head(head),
    .pop(pop), .out_valid(out_valid), .out_ready(out_ready), .res(res)
  );

  assign out_dest_x0      = res.dx0;
  assign out_dest_y0      = res.dy0;
  assign out_dest_x1      = res.dx1;
  assign out_dest_y1      = res.dy1;
  assign out_src_x0       = res.sx0;
  assign out_src_y0       = res.sy0;
  assign out_src_x1       = res.sx1;
  assign out_src_y1       = res.sy1;
  assign out_clear_border = res.clr;
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the grid tile fit and clip unit, with random traffic and configs.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [13:0] w;
    logic [13:0] h;
  } tile_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_cell_row = '0;
  logic [3:0] in_cell_col = '0;
  logic [13:0] in_source_w = '0;
  logic [13:0] in_source_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_dest_x0, out_dest_y0, out_dest_x1, out_dest_y1;
  logic signed [23:0] out_src_x0, out_src_y0, out_src_x1, out_src_y1;
  logic out_clear_border;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = gtf_pkg::CFG_COLS;
  logic [23:0] cfg_data = '0;

  tile_req_t      pending_tiles[$];
  gtf_pkg::res_t  expected_placements[$];
  tile_req_t      tile_on_bus;
  gtf_pkg::cfg_t  grid_cfg;
  int        errors = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        hold_req = 1'b0;
  bit        quiet = 1'b0;

  grid_tile_fit_and_clip_unit i_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint grid_span(logic [4:0] v);
    if (v == 0) return 1;
    if (v > gtf_pkg::MAX_GRID) return gtf_pkg::MAX_GRID;
    return longint'(v);
  endfunction

  function automatic longint crop_shift(longint oob, longint num, longint den, longint zm);
    if (num <= 0 || zm <= 0) return 0;
    return floor_div(oob * den * 256, num * zm);
  endfunction

  function automatic void fit_axis(input longint idx, cell_len, line, size, num, den, zm, pan,
                                   output longint d0, d1, s0, s1);
    longint fitted, ext, left;
    fitted = floor_div(num * size, den);
    ext = floor_div(size * num * zm, den * 256);
    left = idx * (cell_len + line);
    d0 = floor_div(cell_len - fitted, 2) + pan + left;
    d1 = d0 + ext;
    s0 = 0;
    s1 = size * 256;
    if (d0 < left) begin
      s0 += crop_shift(left - d0, num, den, zm);
      d0 = left;
    end else if (d0 >= left + cell_len) begin
      d0 = left + cell_len;
      d1 = d0 + line;
    end
    if (d1 > left + cell_len + line) begin
      s1 -= crop_shift(d1 - (left + cell_len + line), num, den, zm);
      d1 = left + cell_len + line;
    end else if (d1 < left) begin
      d1 = left;
      d0 = d1 - line;
    end
  endfunction

  function automatic gtf_pkg::res_t place_tile(tile_req_t t);
    gtf_pkg::res_t r;
    longint cols, rows, line, tw, th, cw, ch, num, den;
    longint dx0, dx1, dy0, dy1, sx0, sx1, sy0, sy1;
    cols = grid_span(grid_cfg.cols);
    rows = grid_span(grid_cfg.rows);
    line = longint'(grid_cfg.line);
    tw = (t.w == 0) ? 1 : longint'(t.w);
    th = (t.h == 0) ? 1 : longint'(t.h);
    cw = floor_div(longint'(grid_cfg.view_w) * 256 - (cols - 1) * line, cols);
    ch = floor_div(longint'(grid_cfg.view_h) * 256 - (rows - 1) * line, rows);
    if (cw < 0) cw = 0;
    if (ch < 0) ch = 0;
    if (cw * th <= ch * tw) begin
      num = cw;
      den = tw;
    end else begin
      num = ch;
      den = th;
    end
    fit_axis(longint'(t.col), cw, line, tw, num, den, longint'(grid_cfg.zoom),
             longint'(grid_cfg.pan_x), dx0, dx1, sx0, sx1);
    fit_axis(longint'(t.row), ch, line, th, num, den, longint'(grid_cfg.zoom),
             longint'(grid_cfg.pan_y), dy0, dy1, sy0, sy1);
    r.dx0 = clamp24(dx0);
    r.dy0 = clamp24(dy0);
    r.dx1 = clamp24(dx1);
    r.dy1 = clamp24(dy1);
    r.sx0 = clamp24(sx0);
    r.sy0 = clamp24(sy0);
    r.sx1 = clamp24(sx1);
    r.sy1 = clamp24(sy1);
    r.clr = (t.row == 0 && t.col == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_placements.push_back(place_tile(tile_on_bus));
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_tiles.size() > 0) begin
          tile_on_bus = pending_tiles.pop_front();
          in_cell_row <= tile_on_bus.row;
          in_cell_col <= tile_on_bus.col;
          in_source_w <= tile_on_bus.w;
          in_source_h <= tile_on_bus.h;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic signed [23:0] exp_v, logic signed [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    gtf_pkg::res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_placements.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual dest_x0 %0d",
                   $realtime, out_dest_x0);
        end else begin
          e = expected_placements.pop_front();
          check_field("dest_x0", e.dx0, out_dest_x0);
          check_field("dest_y0", e.dy0, out_dest_y0);
          check_field("dest_x1", e.dx1, out_dest_x1);
          check_field("dest_y1", e.dy1, out_dest_y1);
          check_field("src_x0", e.sx0, out_src_x0);
          check_field("src_y0", e.sy0, out_src_y0);
          check_field("src_x1", e.sx1, out_src_x1);
          check_field("src_y1", e.sy1, out_src_y1);
          check_field("clear_border", 24'(e.clr), 24'(out_clear_border));
        end
      end
      if (hold_req) begin
        hold_left = 4000;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gtf_pkg::CFG_COLS:   grid_cfg.cols = val[4:0];
      gtf_pkg::CFG_ROWS:   grid_cfg.rows = val[4:0];
      gtf_pkg::CFG_LINE:   grid_cfg.line = val[15:0];
      gtf_pkg::CFG_VIEW_W: grid_cfg.view_w = val[13:0];
      gtf_pkg::CFG_VIEW_H: grid_cfg.view_h = val[13:0];
      gtf_pkg::CFG_ZOOM:   grid_cfg.zoom = val[15:0];
      gtf_pkg::CFG_PAN_X:  grid_cfg.pan_x = val;
      gtf_pkg::CFG_PAN_Y:  grid_cfg.pan_y = val;
      default: ;
    endcase
  endtask

  task automatic write_all(gtf_pkg::cfg_t c);
    write_reg(gtf_pkg::CFG_COLS, 24'(c.cols));
    write_reg(gtf_pkg::CFG_ROWS, 24'(c.rows));
    write_reg(gtf_pkg::CFG_LINE, 24'(c.line));
    write_reg(gtf_pkg::CFG_VIEW_W, 24'(c.view_w));
    write_reg(gtf_pkg::CFG_VIEW_H, 24'(c.view_h));
    write_reg(gtf_pkg::CFG_ZOOM, 24'(c.zoom));
    write_reg(gtf_pkg::CFG_PAN_X, c.pan_x);
    write_reg(gtf_pkg::CFG_PAN_Y, c.pan_y);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_tiles.size() != 0 || in_valid || expected_placements.size() != 0);
  endtask

  task automatic queue_tile(int row, int col, int w, int h);
    tile_req_t t;
    t.row = 4'(row);
    t.col = 4'(col);
    t.w = 14'(w);
    t.h = 14'(h);
    pending_tiles.push_back(t);
  endtask

  function automatic gtf_pkg::cfg_t random_cfg();
    gtf_pkg::cfg_t c;
    c.cols = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    c.rows = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    c.line = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
    c.view_w = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(64, 8192));
    c.view_h = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(64, 8192));
    c.zoom = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1024));
    c.pan_x = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65536) - 32768);
    c.pan_y = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65536) - 32768);
    return c;
  endfunction

  task automatic queue_random(int n, gtf_pkg::cfg_t c);
    int gc, gr;
    gc = int'(grid_span(c.cols));
    gr = int'(grid_span(c.rows));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        queue_tile($urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 16383), $urandom_range(0, 16383));
      else
        queue_tile($urandom_range(0, gr - 1), $urandom_range(0, gc - 1),
                   $urandom_range(1, 4096), $urandom_range(1, 4096));
    end
  endtask

  initial begin
    gtf_pkg::cfg_t c;
    grid_cfg = '{cols: 5'd1, rows: 5'd1, line: 16'd256, view_w: 14'd1920, view_h: 14'd1080,
                 zoom: 16'd256, pan_x: 24'sd0, pan_y: 24'sd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: size extremes, cells outside the grid
    queue_tile(0, 0, 1920, 1080);
    queue_tile(0, 0, 0, 0);
    queue_tile(15, 15, 16383, 16383);
    queue_tile(0, 1, 8192, 1);
    queue_tile(1, 0, 1, 8192);
    queue_tile(3, 5, 640, 480);
    wait_drained();

    // mixed grid with zoom and pan to clip every edge
    c = '{cols: 5'd4, rows: 5'd3, line: 16'd512, view_w: 14'd1920, view_h: 14'd1080,
          zoom: 16'd1024, pan_x: 24'sd3000, pan_y: -24'sd5000};
    write_all(c);
    queue_tile(0, 0, 1280, 720);
    queue_tile(2, 3, 720, 1280);
    queue_tile(1, 2, 100, 100);
    wait_drained();
    c.pan_x = -24'sd400000;
    c.pan_y = 24'sd400000;
    c.zoom = 16'd64;
    write_all(c);
    queue_tile(0, 1, 1280, 720);
    queue_tile(2, 0, 333, 777);
    wait_drained();

    // zero grid, zero zoom, lines wider than the view
    c = '{cols: 5'd0, rows: 5'd31, line: 16'hFFFF, view_w: 14'd0, view_h: 14'h3FFF,
          zoom: 16'd0, pan_x: 24'sh7FFFFF, pan_y: 24'sh800000};
    write_all(c);
    queue_tile(0, 0, 1, 1);
    queue_tile(15, 15, 16383, 1);
    queue_tile(7, 0, 0, 16383);
    wait_drained();

    // all fields at their top
    c = '{cols: 5'h1F, rows: 5'h1F, line: 16'hFFFF, view_w: 14'h3FFF, view_h: 14'h3FFF,
          zoom: 16'hFFFF, pan_x: 24'sh7FFFFF, pan_y: 24'sh7FFFFF};
    write_all(c);
    queue_tile(15, 15, 16383, 16383);
    queue_tile(0, 0, 1, 1);
    wait_drained();

    // all fields at their bottom
    c = '{cols: 5'd1, rows: 5'd1, line: 16'd0, view_w: 14'd1, view_h: 14'd1,
          zoom: 16'd1, pan_x: 24'sh800000, pan_y: 24'sh800000};
    write_all(c);
    queue_tile(0, 0, 1, 1);
    queue_tile(15, 15, 16383, 16383);
    wait_drained();

    for (int p = 0; p < 11; p++) begin
      c = random_cfg();
      write_all(c);
      quiet = (p == 3);
      queue_random(80, c);
      if (p == 5) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      wait_drained();
    end
    quiet = 1'b0;

    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hw/rtl/gtf_pkg.sv
hw/rtl/gtf_front.sv
hw/rtl/gtf_div.sv
hw/rtl/gtf_back.sv
hw/rtl/grid_tile_fit_and_clip_unit.sv
tb/testbench.sv
